@@ rtl/otua_pkg.sv @@
`timescale 1ns / 1ps

package otua_pkg;

  localparam int NUM_UNITS = 32;
  localparam int IDX_W     = $clog2(NUM_UNITS);
  localparam int CNT_W     = $clog2(NUM_UNITS + 1);
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int QDEPTH    = 2;

  typedef enum logic [2:0] {
    MODE_FIND       = 3'd0,
    MODE_RESERVE    = 3'd1,
    MODE_REBIND     = 3'd2,
    MODE_RELEASE    = 3'd3,
    MODE_INVALIDATE = 3'd4,
    MODE_UNBIND_ALL = 3'd5
  } mode_t;

  // Classified command as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]  mode;
    logic        bad;
    logic [31:0] owner_id;
    logic [31:0] slot;
    logic [31:0] texture_id;
    logic        texture_kind;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FINAL = 2'd2
  } state_t;

endpackage

@@ rtl/otua_front.sv @@
`timescale 1ns / 1ps

module otua_front import otua_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_owner_id,
  input  logic [31:0] in_slot,
  input  logic [31:0] in_texture_id,
  input  logic        in_texture_kind,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic owner_zero;
  logic needs_pair;

  assign owner_zero = (in_owner_id == 32'd0);
  assign needs_pair = (in_mode == MODE_RESERVE) || (in_mode == MODE_REBIND);

  // Commands rejected on their arguments alone skip the table scan.
  always_comb begin
    q_cmd.mode         = in_mode;
    q_cmd.owner_id     = in_owner_id;
    q_cmd.slot         = in_slot;
    q_cmd.texture_id   = in_texture_id;
    q_cmd.texture_kind = in_texture_kind;
    q_cmd.bad          = (in_mode > MODE_UNBIND_ALL) ||
                         (needs_pair && (owner_zero || in_slot[31])) ||
                         ((in_mode == MODE_RELEASE) && owner_zero) ||
                         ((in_mode == MODE_INVALIDATE) && (in_texture_id == 32'd0));
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

endmodule

@@ rtl/otua_cmdq.sv @@
`timescale 1ns / 1ps

module otua_cmdq import otua_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic pop_valid
);

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != QDEPTH[PTR_W:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{PTR_W{1'b0}}, do_push} - {{PTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/otua_back.sv @@
`timescale 1ns / 1ps

module otua_back import otua_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] eff_active,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_bind,
  output logic [4:0]       out_unit_index,
  output logic [31:0]      out_bind_texture,
  output logic             out_bind_kind,
  output logic             out_status,
  output logic [5:0]       out_used_count,
  output logic [5:0]       out_free_count,
  output logic             out_last
);

  // Unit table.
  logic [NUM_UNITS-1:0] used_r;
  logic [31:0]          owner_r [NUM_UNITS];
  logic [31:0]          slot_r  [NUM_UNITS];
  logic [31:0]          tex_r   [NUM_UNITS];
  logic [NUM_UNITS-1:0] kind_r;
  logic [CNT_W-1:0]     used_total_r, used_total_nxt;

  state_t           st_r, st_nxt;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             fin_status_r, fin_status_nxt;
  logic [IDX_W-1:0] fin_unit_r, fin_unit_nxt;

  logic             ov_r, ov_nxt;
  logic             o_bind_r, o_bind_nxt;
  logic [IDX_W-1:0] o_unit_r, o_unit_nxt;
  logic [31:0]      o_tex_r, o_tex_nxt;
  logic             o_kind_r, o_kind_nxt;
  logic             o_status_r, o_status_nxt;
  logic [CNT_W-1:0] o_used_r, o_used_nxt;
  logic [CNT_W-1:0] o_free_r, o_free_nxt;
  logic             o_last_r, o_last_nxt;

  logic [IDX_W-1:0] cur;
  logic             at_end, match, slot_free, tex_hit;
  logic             take, adv, done, emit, load_final;
  logic             do_claim, do_set_tex, do_clr_tex, do_free, do_dec, do_reset_cnt;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] hit_unit;
  logic             hit_status;
  logic [31:0]      emit_tex;
  logic             emit_kind;
  logic [CNT_W-1:0] fin_used;

  assign cur       = idx_r[IDX_W-1:0];
  assign at_end    = (idx_r >= eff_active);
  assign match     = used_r[cur] && (owner_r[cur] == cmd_r.owner_id) &&
                     (slot_r[cur] == cmd_r.slot);
  assign tex_hit   = used_r[cur] && (tex_r[cur] == cmd_r.texture_id);
  assign slot_free = !ov_r || out_ready;
  assign take      = (st_r == ST_IDLE) && q_valid;
  assign q_pop     = take;

  // Scan step decisions.
  always_comb begin
    adv          = 1'b0;
    done         = 1'b0;
    emit         = 1'b0;
    do_claim     = 1'b0;
    do_set_tex   = 1'b0;
    do_clr_tex   = 1'b0;
    do_free      = 1'b0;
    do_dec       = 1'b0;
    do_reset_cnt = 1'b0;
    wr_idx       = cur;
    hit_unit     = fin_unit_r;
    hit_status   = fin_status_r;
    emit_tex     = 32'd0;
    emit_kind    = kind_r[cur];
    if (st_r == ST_SCAN) begin
      if (at_end) begin
        done = 1'b1;
        if ((cmd_r.mode == MODE_RESERVE) && free_found_r) begin
          do_claim   = 1'b1;
          wr_idx     = free_idx_r;
          hit_unit   = free_idx_r;
          hit_status = 1'b0;
        end
        if (cmd_r.mode == MODE_UNBIND_ALL) begin
          do_reset_cnt = 1'b1;
        end
      end else begin
        unique case (cmd_r.mode)
          MODE_FIND, MODE_RESERVE: begin
            if (match) begin
              done       = 1'b1;
              hit_unit   = cur;
              hit_status = 1'b0;
            end else begin
              adv = 1'b1;
            end
          end
          MODE_REBIND: begin
            if (match) begin
              hit_unit   = cur;
              hit_status = 1'b0;
              if ((tex_r[cur] != cmd_r.texture_id) || (kind_r[cur] != cmd_r.texture_kind)) begin
                if (slot_free) begin
                  emit       = 1'b1;
                  emit_tex   = cmd_r.texture_id;
                  emit_kind  = cmd_r.texture_kind;
                  do_set_tex = 1'b1;
                  done       = 1'b1;
                end
              end else begin
                done = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
          MODE_RELEASE: begin
            adv = 1'b1;
            if (used_r[cur] && (owner_r[cur] == cmd_r.owner_id)) begin
              do_free = 1'b1;
              do_dec  = 1'b1;
            end
          end
          MODE_INVALIDATE: begin
            if (tex_hit) begin
              if (slot_free) begin
                emit       = 1'b1;
                do_clr_tex = 1'b1;
                adv        = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
          MODE_UNBIND_ALL: begin
            if (used_r[cur]) begin
              if (tex_r[cur] != 32'd0) begin
                if (slot_free) begin
                  emit    = 1'b1;
                  do_free = 1'b1;
                  adv     = 1'b1;
                end
              end else begin
                do_free = 1'b1;
                adv     = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
    end
  end

  assign load_final = (st_r == ST_FINAL) && slot_free;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (take) begin
          st_nxt = q_cmd.bad ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done) begin
          st_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (load_final) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output register.
  always_comb begin
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    fin_status_nxt = fin_status_r;
    fin_unit_nxt   = fin_unit_r;
    used_total_nxt = used_total_r;
    fin_used       = used_total_r;

    if (take) begin
      idx_nxt        = CNT_W'(1);
      free_found_nxt = 1'b0;
      fin_unit_nxt   = '0;
      fin_status_nxt = q_cmd.bad || (q_cmd.mode == MODE_FIND) ||
                       (q_cmd.mode == MODE_RESERVE) || (q_cmd.mode == MODE_REBIND);
    end
    if (adv) begin
      idx_nxt = idx_r + 1'b1;
    end
    if ((st_r == ST_SCAN) && !at_end && (cmd_r.mode == MODE_RESERVE) &&
        !used_r[cur] && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = cur;
    end
    if (done) begin
      fin_unit_nxt   = hit_unit;
      fin_status_nxt = hit_status;
    end
    if (do_claim && (used_total_r != CNT_W'(CNT_MAX))) begin
      used_total_nxt = used_total_r + 1'b1;
    end
    if (do_dec && (used_total_r != '0)) begin
      used_total_nxt = used_total_r - 1'b1;
    end
    if (do_reset_cnt) begin
      used_total_nxt = CNT_W'(1);
    end

    // Binds only come from modes whose final count is already known.
    if (cmd_r.mode == MODE_UNBIND_ALL) begin
      fin_used = CNT_W'(1);
    end

    ov_nxt       = ov_r && !out_ready;
    o_bind_nxt   = o_bind_r;
    o_unit_nxt   = o_unit_r;
    o_tex_nxt    = o_tex_r;
    o_kind_nxt   = o_kind_r;
    o_status_nxt = o_status_r;
    o_used_nxt   = o_used_r;
    o_free_nxt   = o_free_r;
    o_last_nxt   = o_last_r;
    if (emit) begin
      ov_nxt       = 1'b1;
      o_bind_nxt   = 1'b1;
      o_unit_nxt   = cur;
      o_tex_nxt    = emit_tex;
      o_kind_nxt   = emit_kind;
      o_status_nxt = 1'b0;
      o_used_nxt   = fin_used;
      o_free_nxt   = (eff_active > fin_used) ? eff_active - fin_used : '0;
      o_last_nxt   = 1'b0;
    end else if (load_final) begin
      ov_nxt       = 1'b1;
      o_bind_nxt   = 1'b0;
      o_unit_nxt   = fin_unit_r;
      o_tex_nxt    = 32'd0;
      o_kind_nxt   = 1'b0;
      o_status_nxt = fin_status_r;
      o_used_nxt   = used_total_r;
      o_free_nxt   = (eff_active > used_total_r) ? eff_active - used_total_r : '0;
      o_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      ov_r         <= 1'b0;
      used_total_r <= CNT_W'(1);
      used_r       <= {{(NUM_UNITS-1){1'b0}}, 1'b1};
      kind_r       <= '0;
      for (int i = 0; i < NUM_UNITS; i++) begin
        owner_r[i] <= 32'd0;
        slot_r[i]  <= 32'd0;
        tex_r[i]   <= 32'd0;
      end
    end else begin
      st_r         <= st_nxt;
      ov_r         <= ov_nxt;
      used_total_r <= used_total_nxt;
      if (do_claim) begin
        used_r[wr_idx]  <= 1'b1;
        owner_r[wr_idx] <= cmd_r.owner_id;
        slot_r[wr_idx]  <= cmd_r.slot;
        tex_r[wr_idx]   <= 32'd0;
        kind_r[wr_idx]  <= 1'b0;
      end
      if (do_set_tex) begin
        tex_r[wr_idx]  <= cmd_r.texture_id;
        kind_r[wr_idx] <= cmd_r.texture_kind;
      end
      if (do_clr_tex) begin
        tex_r[wr_idx] <= 32'd0;
      end
      if (do_free) begin
        used_r[wr_idx]  <= 1'b0;
        owner_r[wr_idx] <= 32'd0;
        slot_r[wr_idx]  <= 32'd0;
        tex_r[wr_idx]   <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= q_cmd;
    end
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    fin_status_r <= fin_status_nxt;
    fin_unit_r   <= fin_unit_nxt;
    o_bind_r     <= o_bind_nxt;
    o_unit_r     <= o_unit_nxt;
    o_tex_r      <= o_tex_nxt;
    o_kind_r     <= o_kind_nxt;
    o_status_r   <= o_status_nxt;
    o_used_r     <= o_used_nxt;
    o_free_r     <= o_free_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_is_bind      = o_bind_r;
  assign out_unit_index   = o_unit_r;
  assign out_bind_texture = o_tex_r;
  assign out_bind_kind    = o_kind_r;
  assign out_status       = o_status_r;
  assign out_used_count   = o_used_r;
  assign out_free_count   = o_free_r;
  assign out_last         = o_last_r;

  a_unit0_kept: assert property (@(posedge clk) disable iff (!rst_n) used_r[0])
    else $error("reserved unit 0 lost its used mark");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable({o_bind_r, o_unit_r, o_tex_r, o_kind_r,
                                            o_status_r, o_used_r, o_free_r, o_last_r}))
    else $error("result transaction changed while it waited");

  a_idle_no_bind: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) && ov_r |-> o_last_r)
    else $error("bind transaction pending while idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (idx_r <= eff_active))
    else $error("scan index ran past the active units");

endmodule

@@ rtl/owner_tagged_unit_allocator_core.sv @@
`timescale 1ns / 1ps

// Owner-tagged texture unit allocator. Commands (find, reserve, rebind,
// release_owner, invalidate_texture, unbind_all) arrive as transactions on
// the in_ channel and are classified by a front end that flags bad
// arguments; a two-entry command queue then decouples it from the
// back end, which owns the unit table and walks units 1 .. A-1 one unit per
// clock, where A is active_units clamped to 1 .. 32. Each command yields zero
// or more bind transactions (out_is_bind high) and then exactly one final
// status transaction with out_last high. A command is taken from the queue,
// then the table is scanned (find, reserve and rebind stop at the first
// match) and the final result is loaded; a command flagged as bad skips the
// scan. The scan also holds on a unit that needs a bind for as long as the
// output register still holds an unaccepted transaction.
// The next command can be queued while the current one is being scanned.
// Write active_units only while the block is idle.

module owner_tagged_unit_allocator_core import otua_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_owner_id,
  input  logic [31:0] in_slot,
  input  logic [31:0] in_texture_id,
  input  logic        in_texture_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_bind,
  output logic [4:0]  out_unit_index,
  output logic [31:0] out_bind_texture,
  output logic        out_bind_kind,
  output logic        out_status,
  output logic [5:0]  out_used_count,
  output logic [5:0]  out_free_count,
  output logic        out_last
);

  logic [5:0]       active_units_r;
  logic [CNT_W-1:0] eff_active;
  logic             q_ready, q_push, q_valid, q_pop;
  cmd_t             push_cmd, pop_cmd;

  // The platform limit register resets to the full table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_units_r <= 6'd32;
    end else if (cfg_wr_en) begin
      active_units_r <= cfg_wr_data;
    end
  end

  // Clamp the limit to at least one unit and at most the table size.
  always_comb begin
    if (active_units_r == 6'd0) begin
      eff_active = CNT_W'(1);
    end else if (active_units_r > 6'(NUM_UNITS)) begin
      eff_active = CNT_W'(NUM_UNITS);
    end else begin
      eff_active = CNT_W'(active_units_r);
    end
  end

  otua_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_owner_id     (in_owner_id),
    .in_slot         (in_slot),
    .in_texture_id   (in_texture_id),
    .in_texture_kind (in_texture_kind),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  otua_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (q_valid)
  );

  otua_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .eff_active       (eff_active),
    .q_valid          (q_valid),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_bind      (out_is_bind),
    .out_unit_index   (out_unit_index),
    .out_bind_texture (out_bind_texture),
    .out_bind_kind    (out_bind_kind),
    .out_status       (out_status),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count),
    .out_last         (out_last)
  );

endmodule

@@ dv/owner_tagged_unit_allocator_core_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the owner-tagged texture unit allocator. It keeps its own copy
// of the unit table and predicts every result of every command. Results are
// checked in order, field by field, against a queue of expected transactions.
module owner_tagged_unit_allocator_core_tb import otua_pkg::*;;

  localparam int UNITS = 32;

  // One expected result transaction.
  typedef struct {
    logic        is_bind;
    logic [4:0]  unit_index;
    logic [31:0] bind_texture;
    logic        bind_kind;
    logic        status;
    logic [5:0]  used_count;
    logic [5:0]  free_count;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [31:0] in_owner_id;
  logic [31:0] in_slot;
  logic [31:0] in_texture_id;
  logic        in_texture_kind;
  logic        out_valid;
  logic        out_ready;
  logic        out_is_bind;
  logic [4:0]  out_unit_index;
  logic [31:0] out_bind_texture;
  logic        out_bind_kind;
  logic        out_status;
  logic [5:0]  out_used_count;
  logic [5:0]  out_free_count;
  logic        out_last;

  owner_tagged_unit_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_owner_id(in_owner_id), .in_slot(in_slot), .in_texture_id(in_texture_id),
    .in_texture_kind(in_texture_kind),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_bind(out_is_bind),
    .out_unit_index(out_unit_index), .out_bind_texture(out_bind_texture),
    .out_bind_kind(out_bind_kind), .out_status(out_status),
    .out_used_count(out_used_count), .out_free_count(out_free_count),
    .out_last(out_last)
  );

  // Shadow copy of the unit table and the active_units register.
  logic [5:0]  tbl_active;
  logic        tbl_used   [UNITS];
  logic [31:0] tbl_owner  [UNITS];
  logic [31:0] tbl_slot   [UNITS];
  logic [31:0] tbl_tex    [UNITS];
  logic        tbl_kind   [UNITS];
  int unsigned tbl_used_total;

  result_t pending_results[$];
  int      mismatch_count;
  bit      no_idle;          // Disables random idling on both sides.

  // Owners and slots drawn from small pools so that finds and rebinds hit.
  logic [31:0] owner_pool[4] = '{32'd1, 32'd7, 32'hFFFF_FFFF, 32'h8000_0000};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned scan_limit();
    int unsigned a;
    a = {26'd0, tbl_active};
    if (a < 1) a = 1;
    if (a > UNITS) a = UNITS;
    return a;
  endfunction

  function automatic void reset_table();
    tbl_active = 6'd32;
    for (int i = 0; i < UNITS; i++) begin
      tbl_used[i]  = (i == 0);
      tbl_owner[i] = '0;
      tbl_slot[i]  = '0;
      tbl_tex[i]   = '0;
      tbl_kind[i]  = 1'b0;
    end
    tbl_used_total = 1;
  endfunction

  function automatic int lookup_unit(logic [31:0] owner, logic [31:0] slot);
    for (int i = 1; i < scan_limit(); i++)
      if (tbl_used[i] && tbl_owner[i] == owner && tbl_slot[i] == slot) return i;
    return -1;
  endfunction

  // Applies one command to the shadow table and queues every result it causes.
  function automatic void predict_command(logic [2:0] mode, logic [31:0] owner,
                                          logic [31:0] slot, logic [31:0] tex,
                                          logic kind);
    result_t     binds[$];
    result_t     r;
    int unsigned a;
    int          u;
    logic        status;
    logic [4:0]  unit;
    a = scan_limit();
    status = 1'b1;
    unit = '0;
    case (mode)
      MODE_FIND: begin
        u = lookup_unit(owner, slot);
        if (u >= 0) begin
          status = 1'b0;
          unit = u[4:0];
        end
      end
      MODE_RESERVE: begin
        if (owner != 0 && !slot[31]) begin
          u = lookup_unit(owner, slot);
          if (u >= 0) begin
            status = 1'b0;
            unit = u[4:0];
          end else begin
            for (int i = 1; i < a; i++) begin
              if (!tbl_used[i]) begin
                tbl_used[i] = 1'b1;
                tbl_owner[i] = owner;
                tbl_slot[i] = slot;
                tbl_tex[i] = '0;
                tbl_kind[i] = 1'b0;
                if (tbl_used_total < 63) tbl_used_total++;
                status = 1'b0;
                unit = i[4:0];
                break;
              end
            end
          end
        end
      end
      MODE_REBIND: begin
        if (owner != 0 && !slot[31]) begin
          u = lookup_unit(owner, slot);
          if (u >= 0) begin
            status = 1'b0;
            unit = u[4:0];
            if (tbl_tex[u] != tex || tbl_kind[u] != kind) begin
              r = '{1'b1, u[4:0], tex, kind, 1'b0, 6'd0, 6'd0, 1'b0};
              binds.push_back(r);
              tbl_tex[u] = tex;
              tbl_kind[u] = kind;
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (owner != 0) begin
          status = 1'b0;
          for (int i = 1; i < a; i++) begin
            if (tbl_used[i] && tbl_owner[i] == owner) begin
              tbl_used[i] = 1'b0;
              tbl_tex[i] = '0;
              tbl_owner[i] = '0;
              tbl_slot[i] = '0;
              if (tbl_used_total > 0) tbl_used_total--;
            end
          end
        end
      end
      MODE_INVALIDATE: begin
        if (tex != 0) begin
          status = 1'b0;
          for (int i = 1; i < a; i++) begin
            if (tbl_used[i] && tbl_tex[i] == tex) begin
              r = '{1'b1, i[4:0], 32'd0, tbl_kind[i], 1'b0, 6'd0, 6'd0, 1'b0};
              binds.push_back(r);
              tbl_tex[i] = '0;
            end
          end
        end
      end
      MODE_UNBIND_ALL: begin
        status = 1'b0;
        for (int i = 1; i < a; i++) begin
          if (tbl_used[i]) begin
            if (tbl_tex[i] != 0) begin
              r = '{1'b1, i[4:0], 32'd0, tbl_kind[i], 1'b0, 6'd0, 6'd0, 1'b0};
              binds.push_back(r);
            end
            tbl_used[i] = 1'b0;
            tbl_tex[i] = '0;
            tbl_owner[i] = '0;
            tbl_slot[i] = '0;
          end
        end
        tbl_used_total = 1;
      end
      default: ;
    endcase
    r = '{1'b0, unit, 32'd0, 1'b0, status, 6'd0, 6'd0, 1'b1};
    binds.push_back(r);
    // Counts reflect the table after the whole command, on every result.
    foreach (binds[k]) begin
      binds[k].used_count = tbl_used_total[5:0];
      binds[k].free_count = (a > tbl_used_total) ? 6'(a - tbl_used_total) : 6'd0;
      pending_results.push_back(binds[k]);
    end
  endfunction

  // Sends one command transaction and predicts its results on acceptance.
  // Valid is dropped only while idling, by the drain task or at the run's end.
  task automatic send_command(logic [2:0] mode, logic [31:0] owner,
                              logic [31:0] slot, logic [31:0] tex, logic kind);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_owner_id <= owner;
    in_slot <= slot;
    in_texture_id <= tex;
    in_texture_kind <= kind;
    do @(posedge clk); while (!in_ready);
    predict_command(mode, owner, slot, tex, kind);
    @(negedge clk);
  endtask

  // Waits until every expected result has come, plus the scan time of a
  // command that causes nothing but its final result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_active(logic [5:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tbl_active = value;
  endtask

  // Sink side: random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= 23);
    end
  end

  // Compare each accepted result in order.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result transaction with nothing expected (unit %0d)",
                   out_unit_index);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_is_bind !== exp_r.is_bind || out_unit_index !== exp_r.unit_index ||
            out_bind_texture !== exp_r.bind_texture ||
            out_bind_kind !== exp_r.bind_kind || out_status !== exp_r.status ||
            out_used_count !== exp_r.used_count ||
            out_free_count !== exp_r.free_count || out_last !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: expected bind=%0d unit=%0d tex=%h kind=%0d st=%0d ",
                      "used=%0d free=%0d last=%0d, got bind=%0d unit=%0d tex=%h ",
                      "kind=%0d st=%0d used=%0d free=%0d last=%0d"},
                     exp_r.is_bind, exp_r.unit_index, exp_r.bind_texture,
                     exp_r.bind_kind, exp_r.status, exp_r.used_count,
                     exp_r.free_count, exp_r.last, out_is_bind, out_unit_index,
                     out_bind_texture, out_bind_kind, out_status, out_used_count,
                     out_free_count, out_last);
        end
      end
    end
  end

  // Extremes of each field, every mode, and each special case.
  task automatic test_directed();
    send_command(MODE_FIND, 32'd0, 32'd0, 32'd0, 1'b0);          // no match
    send_command(MODE_RESERVE, 32'd0, 32'd1, 32'd0, 1'b0);       // owner zero
    send_command(MODE_RESERVE, 32'd1, 32'h8000_0000, 32'd0, 1'b0); // negative
    send_command(MODE_RESERVE, 32'd1, 32'd0, 32'd0, 1'b0);
    send_command(MODE_RESERVE, 32'd1, 32'd0, 32'd0, 1'b0);       // existing
    send_command(MODE_RESERVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_command(MODE_FIND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_command(MODE_REBIND, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_command(MODE_REBIND, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1); // unchanged
    send_command(MODE_REBIND, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0); // kind only
    send_command(MODE_REBIND, 32'd9, 32'd0, 32'd5, 1'b0);        // unowned
    send_command(MODE_REBIND, 32'd0, 32'd0, 32'd5, 1'b0);
    send_command(MODE_REBIND, 32'd1, 32'hFFFF_FFFF, 32'd5, 1'b0);
    send_command(MODE_REBIND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_command(MODE_INVALIDATE, 32'd0, 32'd0, 32'd0, 1'b0);    // texture zero
    send_command(MODE_INVALIDATE, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_command(MODE_RELEASE, 32'd0, 32'd0, 32'd0, 1'b0);       // owner zero
    send_command(MODE_RELEASE, 32'd55, 32'd0, 32'd0, 1'b0);      // frees nothing
    send_command(MODE_RELEASE, 32'd1, 32'd0, 32'd0, 1'b0);
    send_command(MODE_REBIND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd3, 1'b1);
    send_command(MODE_UNBIND_ALL, 32'd0, 32'd0, 32'd0, 1'b0);
    send_command(3'd6, 32'd1, 32'd1, 32'd1, 1'b1);               // unknown mode
    send_command(3'd7, 32'd0, 32'd0, 32'd0, 1'b0);
  endtask

  // Fills the table to the limit and keeps reserving past it.
  task automatic test_full_table(logic [5:0] active);
    write_active(active);
    for (int i = 0; i < UNITS + 1; i++)
      send_command(MODE_RESERVE, 32'd3, i, 32'd0, 1'b0);
    send_command(MODE_UNBIND_ALL, 32'd0, 32'd0, 32'd0, 1'b0);
  endtask

  // Random commands weighted toward well-formed use of a small owner set.
  task automatic test_random(int count, logic [5:0] active);
    logic [2:0]  mode;
    logic [31:0] owner, slot, tex;
    int          pick;
    write_active(active);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      mode = (pick < 35) ? MODE_RESERVE : (pick < 65) ? MODE_REBIND :
             (pick < 75) ? MODE_FIND : (pick < 83) ? MODE_INVALIDATE :
             (pick < 90) ? MODE_RELEASE : (pick < 93) ? MODE_UNBIND_ALL :
             3'($urandom_range(7));
      owner = ($urandom_range(9) == 0) ? $urandom : owner_pool[$urandom_range(3)];
      slot = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5);
      tex = ($urandom_range(5) == 0) ? $urandom : $urandom_range(3);
      send_command(mode, owner, slot, tex, 1'($urandom_range(1)));
      if (n == count / 2) wait_drained();   // let the block run dry mid-phase
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_mode = '0;
    in_owner_id = '0;
    in_slot = '0;
    in_texture_id = '0;
    in_texture_kind = 1'b0;
    no_idle = 1'b0;
    mismatch_count = 0;
    reset_table();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_table(6'd4);
    test_full_table(6'd0);
    test_random(80, 6'd32);
    no_idle = 1'b1;
    test_random(60, 6'd63);
    no_idle = 1'b0;
    test_random(80, 6'd5);
    test_random(40, 6'd1);
    test_random(30, 6'd42);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100_000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/otua_pkg.sv
rtl/otua_front.sv
rtl/otua_cmdq.sv
rtl/otua_back.sv
rtl/owner_tagged_unit_allocator_core.sv
dv/owner_tagged_unit_allocator_core_tb.sv
